### rtl/core/itp_pkg.sv
`default_nettype none

package itp_pkg;

    // default operator stack depth
    localparam int ITP_STACK_DEPTH = 32;

    // character codes
    localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
    localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
    localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
    localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
    localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_Z  = 8'h7A;  // 'z'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
    localparam logic [7:0] CASE_OFS = 8'h20;  // upper to lower offset

    // priorities
    localparam logic [1:0] PRIO_NONE = 2'd0;
    localparam logic [1:0] PRIO_OPEN = 2'd1;
    localparam logic [1:0] PRIO_ADD  = 2'd2;
    localparam logic [1:0] PRIO_MUL  = 2'd3;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNMATCHED = 2'd2
    } status_t;

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MAIN   = 6'b000010,
        ST_CLOSE  = 6'b000100,
        ST_OPER   = 6'b001000,
        ST_TAIL   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // operator priority of a character
    function automatic logic [1:0] prio_of(input logic [7:0] c);
        logic [1:0] p;
        p = PRIO_NONE;
        if (c == CH_MUL || c == CH_DIV)
        begin
            p = PRIO_MUL;
        end
        else if (c == CH_ADD || c == CH_SUB)
        begin
            p = PRIO_ADD;
        end
        else if (c == CH_OPEN)
        begin
            p = PRIO_OPEN;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/core/itp_stack.sv
`default_nettype none

module itp_stack
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = ITP_STACK_DEPTH,
    localparam int IDX_W = $clog2(STACK_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [7:0]       wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [7:0]       rd_data
);

    logic [7:0] mem [STACK_DEPTH];
    logic [7:0] rd_data_reg;

    // stack storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered top-of-stack read; a push becomes the new top at once
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rd_data_reg <= wr_data;
        end
        else if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/infix_to_postfix_converter.sv
// channel | signals                                         | beat taken when
// input   | in_valid, in_ready, char_in, end_of_expr        | in_valid & in_ready
// output  | out_valid, out_ready, symbol, has_symbol,       | out_valid & out_ready
//         | is_last, status                                 |
//
// one character at a time: each character passes ST_MAIN and ST_FINISH, with
// ST_CLOSE for a ')' or ST_OPER for an operator, ST_TAIL for the flush of an
// end character and a bare end marker from ST_FINISH; each popped symbol is
// one pass of the pop loop, which is bound by the registered stack read.
// rst_n clears the stack count and all control; stack contents stay undefined.
// a result waits in a staging register until the next one (or the end of the
// character) is known; a stalled output only holds the loop when both are full.
`default_nettype none

module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = ITP_STACK_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_in,
    input  wire logic       end_of_expr,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      symbol,
    output logic            has_symbol,
    output logic            is_last,
    output logic [1:0]      status
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] open_reg, open_next;
    logic [7:0]       char_reg, char_next;
    logic             end_reg, end_next;
    status_t          status_reg, status_next;
    logic             stage_v_reg, stage_v_next;
    logic [7:0]       stage_sym_reg, stage_sym_next;
    logic             stage_has_reg, stage_has_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_sym_reg, out_sym_next;
    logic             out_has_reg, out_has_next;
    logic             out_last_reg, out_last_next;
    status_t          out_status_reg, out_status_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [7:0]       top;
    logic [CNT_W-1:0] cnt_dec1;
    logic [CNT_W-1:0] cnt_dec2;

    logic             in_fire;
    logic             out_free;
    logic             can_emit;
    logic             emit;
    logic [7:0]       emit_sym;
    logic             emit_has;
    logic             fin;
    logic             do_pop;
    logic             do_push;
    logic             stack_full;
    logic [1:0]       char_prio;
    logic [1:0]       top_prio;
    logic             is_lower;
    logic             is_upper;

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (top)
    );

    // handshake and classification
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign can_emit   = !stage_v_reg || out_free;
    assign stack_full = (count_reg == CNT_FULL);
    assign char_prio  = prio_of(char_reg);
    assign top_prio   = prio_of(top);
    assign is_lower   = (char_reg >= CH_LO_A) && (char_reg <= CH_LO_Z);
    assign is_upper   = (char_reg >= CH_UP_A) && (char_reg <= CH_UP_Z);

    // controller
    always_comb
    begin
        state_next  = state_reg;
        char_next   = char_reg;
        end_next    = end_reg;
        status_next = status_reg;
        emit        = 1'b0;
        emit_sym    = top;
        emit_has    = 1'b1;
        fin         = 1'b0;
        do_pop      = 1'b0;
        do_push     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    char_next   = char_in;
                    end_next    = end_of_expr;
                    status_next = STATUS_OK;
                    state_next  = ST_MAIN;
                end
            end
            ST_MAIN:
            begin
                priority if (is_lower || is_upper)
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        emit_sym   = is_upper ? (char_reg + CASE_OFS) : char_reg;
                        state_next = end_reg ? ST_TAIL : ST_FINISH;
                    end
                end
                else if (char_reg == CH_OPEN)
                begin
                    if (stack_full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                    state_next = end_reg ? ST_TAIL : ST_FINISH;
                end
                else if (char_reg == CH_CLOSE)
                begin
                    status_next = (open_reg == '0) ? STATUS_UNMATCHED : STATUS_OK;
                    state_next  = ST_CLOSE;
                end
                else if (char_prio >= PRIO_ADD)
                begin
                    // a full stack with nothing to pop drops the push
                    if (stack_full && (top_prio < char_prio))
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    state_next = ST_OPER;
                end
                else
                begin
                    state_next = end_reg ? ST_TAIL : ST_FINISH;
                end
            end
            ST_CLOSE:
            begin
                if (count_reg == '0)
                begin
                    state_next = end_reg ? ST_TAIL : ST_FINISH;
                end
                else if (top == CH_OPEN)
                begin
                    do_pop     = 1'b1;
                    state_next = end_reg ? ST_TAIL : ST_FINISH;
                end
                else if (can_emit)
                begin
                    emit   = 1'b1;
                    do_pop = 1'b1;
                end
            end
            ST_OPER:
            begin
                if ((count_reg != '0) && (top_prio >= char_prio))
                begin
                    if (can_emit)
                    begin
                        emit   = 1'b1;
                        do_pop = 1'b1;
                    end
                end
                else
                begin
                    do_push    = !stack_full;
                    state_next = end_reg ? ST_TAIL : ST_FINISH;
                end
            end
            ST_TAIL:
            begin
                // flush the whole stack, open parentheses included
                if (count_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (can_emit)
                begin
                    emit   = 1'b1;
                    do_pop = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (stage_v_reg)
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (end_reg || (status_reg != STATUS_OK))
                begin
                    // bare end marker
                    emit     = 1'b1;
                    emit_sym = 8'h00;
                    emit_has = 1'b0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // addresses one and two below the stack count
    assign cnt_dec1 = count_reg - CNT_ONE;
    assign cnt_dec2 = count_reg - CNT_TWO;

    // stack pointer, open-parenthesis count and memory requests
    always_comb
    begin
        count_next = count_reg;
        open_next  = open_reg;
        mem_we     = do_push;
        mem_waddr  = count_reg[IDX_W-1:0];
        mem_wdata  = char_reg;
        mem_re     = 1'b0;
        mem_raddr  = cnt_dec1[IDX_W-1:0];
        if (in_fire)
        begin
            mem_re = 1'b1;
        end
        if (do_pop)
        begin
            count_next = cnt_dec1;
            mem_re     = 1'b1;
            mem_raddr  = cnt_dec2[IDX_W-1:0];
            if (top == CH_OPEN)
            begin
                open_next = open_reg - CNT_ONE;
            end
        end
        if (do_push)
        begin
            count_next = count_reg + CNT_ONE;
            if (char_reg == CH_OPEN)
            begin
                open_next = open_reg + CNT_ONE;
            end
        end
    end

    // staging register and output register
    always_comb
    begin
        stage_v_next    = stage_v_reg;
        stage_sym_next  = stage_sym_reg;
        stage_has_next  = stage_has_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sym_next    = out_sym_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        if ((emit && stage_v_reg) || fin)
        begin
            out_valid_next  = 1'b1;
            out_sym_next    = stage_sym_reg;
            out_has_next    = stage_has_reg;
            out_last_next   = fin;
            out_status_next = status_next;
        end
        if (emit)
        begin
            stage_v_next   = 1'b1;
            stage_sym_next = emit_sym;
            stage_has_next = emit_has;
        end
        if (fin)
        begin
            stage_v_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            open_reg      <= '0;
            stage_v_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            open_reg      <= open_next;
            stage_v_reg   <= stage_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        end_reg        <= end_next;
        status_reg     <= status_next;
        stage_sym_reg  <= stage_sym_next;
        stage_has_reg  <= stage_has_next;
        out_sym_reg    <= out_sym_next;
        out_has_reg    <= out_has_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign symbol     = out_sym_reg;
    assign has_symbol = out_has_reg;
    assign is_last    = out_last_reg;
    assign status     = out_status_reg;

    // stack count never exceeds the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("stack count beyond depth");

    // open parentheses are a subset of the stacked entries
    a_open_range: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= count_reg)
        else $error("open count exceeds stack count");

    // no staged result is left behind when a new character may enter
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stage_v_reg)
        else $error("staged result left over in idle");

    // a push leaves the pushed character on top of the stack
    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> (top == $past(char_reg)) && (count_reg == $past(count_reg) + CNT_ONE))
        else $error("push did not update the top of stack");

endmodule

`default_nettype wire
